// ----- rtl/chsi_pkg.sv -----
// ----------------------------------------------------------------------------
// chsi_pkg - cubic Hermite segment interpolator package
// Shared widths, payload types, command codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package chsi_pkg;

  localparam int FRAC_BITS_DEF     = 25;
  localparam int DURATION_BITS_DEF = 16;

  localparam int POS_W  = 32;
  localparam int SPD_W  = 16;
  localparam int DUR_W  = 16;
  localparam int STEP_W = 16;

  localparam int DIV_STEPS = 64;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [SPD_W-1:0] spd_t;
  typedef logic [DUR_W-1:0]        dur_t;
  typedef logic [STEP_W-1:0]       step_t;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    L_T2,
    L_T3,
    L_M1,
    L_M2,
    L_QA,
    L_QB,
    K_TT,
    K_TTT,
    K_P1,
    K_P2,
    K_P3,
    K_S1,
    K_S2
  } st_t;

endpackage

`default_nettype wire

// ----- rtl/chsi_if.sv -----
// ----------------------------------------------------------------------------
// chsi_if - valid/ready channels of the segment interpolator
// Command channel (load or tick) and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface chsi_in_if;
  logic          valid;
  logic          ready;
  chsi_pkg::cmd_t cmd;
  chsi_pkg::pos_t start_position;
  chsi_pkg::spd_t start_speed;
  chsi_pkg::pos_t end_position;
  chsi_pkg::spd_t end_speed;
  chsi_pkg::dur_t duration;

  modport source (
    output valid, cmd, start_position, start_speed, end_position, end_speed, duration,
    input  ready
  );
  modport sink (
    input  valid, cmd, start_position, start_speed, end_position, end_speed, duration,
    output ready
  );
endinterface

interface chsi_out_if;
  logic            valid;
  logic            ready;
  chsi_pkg::pos_t  desired_position;
  chsi_pkg::spd_t  speed_feedforward;
  chsi_pkg::step_t step_index;

  modport source (
    output valid, desired_position, speed_feedforward, step_index,
    input  ready
  );
  modport sink (
    input  valid, desired_position, speed_feedforward, step_index,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/cubic_hermite_segment_interpolator.sv -----
// ----------------------------------------------------------------------------
// cubic_hermite_segment_interpolator - fixed-point cubic Hermite trajectory
//
// in_ch carries commands. A load beat (cmd = CMD_LOAD) sets up a segment and
// gives no result; a tick beat (cmd = CMD_TICK) advances the step and gives
// one result beat on out_ch while the step is below the segment duration.
// All products and quotients run through one 32x32 multiplier (a 64-bit product
// mod 2^64) and one restoring divider (one quotient bit per cycle).
// Load: in_ch.ready drops for four products plus two 64-step divisions; with
//   zero duration the divisions are skipped.
// Tick: from accept to result, seven products and their sums.
//   A tick past the segment end is taken and dropped.
// in_ch.ready is high only while the sequencer is idle.
// out_ch is registered; a stalled result holds, loads still proceed, and a
// new result waits in the last sequencer step until the old beat is taken.
// Reset clears the segment, so ticks give nothing until the first load.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_hermite_segment_interpolator #(
  parameter int FRAC_BITS     = chsi_pkg::FRAC_BITS_DEF,
  parameter int DURATION_BITS = chsi_pkg::DURATION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  chsi_in_if.sink   in_ch,
  chsi_out_if.source out_ch
);

  import chsi_pkg::*;

  localparam int DB   = DURATION_BITS;
  localparam int T2_W = 2 * DURATION_BITS;
  localparam int T3_W = 3 * DURATION_BITS;

  st_t state_r, state_nxt;
  st_t ret_r, ret_nxt;

  logic [1:0]       mcnt_r, mcnt_nxt;
  logic [5:0]       dcnt_r, dcnt_nxt;

  logic [63:0]      mx_r, mx_nxt;
  logic [63:0]      my_r, my_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [63:0]      wk_r, wk_nxt;
  logic [63:0]      b_r, b_nxt;

  logic [63:0]      num_r, num_nxt;
  logic [T3_W-1:0]  rem_r, rem_nxt;
  logic [T3_W-1:0]  dv_r, dv_nxt;
  logic             neg_r, neg_nxt;

  logic [T2_W-1:0]  t2_r, t2_nxt;
  logic [T3_W-1:0]  t3_r, t3_nxt;
  logic [T2_W-1:0]  tt_r, tt_nxt;
  logic signed [32:0] d_r, d_nxt;
  logic signed [16:0] sv_r, sv_nxt;
  logic signed [17:0] sv2_r, sv2_nxt;

  pos_t             base_pos_r, base_pos_nxt;
  spd_t             base_spd_r, base_spd_nxt;
  logic [DB-1:0]    seg_len_r, seg_len_nxt;
  logic [DB-1:0]    step_r, step_nxt;
  logic [63:0]      ca_r, ca_nxt;
  logic [63:0]      cb_r, cb_nxt;
  logic [63:0]      cc_r, cc_nxt;
  pos_t             pos_r, pos_nxt;

  logic             out_valid_r, out_valid_nxt;
  pos_t             out_pos_r, out_pos_nxt;
  spd_t             out_spd_r, out_spd_nxt;
  step_t            out_step_r, out_step_nxt;

  logic             in_acc;
  logic             tick_live;
  logic             out_free;

  logic [31:0]      ma, mb;
  logic [T3_W:0]    rem_sh, rem_diff;
  logic             qbit;
  logic [63:0]      pre_x, pre_d, pre_num;
  logic             pre_neg;
  logic [63:0]      q_fix;
  logic [63:0]      d64, sum64;
  logic [16:0]      spd17;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tick_live   = (step_r < seg_len_r);
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.desired_position  = out_pos_r;
  assign out_ch.speed_feedforward = out_spd_r;
  assign out_ch.step_index        = out_step_r;

  // shared 32x32 multiplier, partial product picked by mcnt
  always_comb begin
    case (mcnt_r)
      2'd1:    begin ma = mx_r[31:0];  mb = my_r[63:32]; end
      2'd2:    begin ma = mx_r[63:32]; mb = my_r[31:0];  end
      default: begin ma = mx_r[31:0];  mb = my_r[31:0];  end
    endcase
    prod_nxt = 64'(ma) * 64'(mb);
  end

  // restoring divider step, rounding pre/post processing and tick sums
  always_comb begin
    rem_sh   = {rem_r, num_r[63]};
    rem_diff = rem_sh - {1'b0, dv_r};
    qbit     = !rem_diff[T3_W];
    pre_x    = (state_r == L_M2) ? wk_r : b_r;
    pre_d    = (state_r == L_M2) ? 64'(t3_r) : 64'(t2_r);
    pre_neg  = pre_x[63] || (pre_x == 64'd0);
    pre_num  = (pre_neg ? (64'd0 - pre_x) : pre_x) + (pre_d >> 1);
    q_fix    = neg_r ? (64'd0 - num_r) : num_r;
    d64      = 64'(d_r);
    sum64    = wk_r + acc_r;
    spd17    = sum64[FRAC_BITS+16:FRAC_BITS] + 17'(base_spd_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_LOAD) begin
            state_nxt = S_MUL;
            ret_nxt   = L_T2;
          end else if (tick_live) begin
            state_nxt = S_MUL;
            ret_nxt   = K_TT;
          end
        end
      end
      S_MUL:  if (mcnt_r == 2'd3) state_nxt = ret_r;
      S_DIV:  if (dcnt_r == 6'(DIV_STEPS - 1)) state_nxt = ret_r;
      L_T2:   begin state_nxt = S_MUL; ret_nxt = L_T3; end
      L_T3:   begin state_nxt = S_MUL; ret_nxt = L_M1; end
      L_M1:   begin state_nxt = S_MUL; ret_nxt = L_M2; end
      L_M2: begin
        if (seg_len_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DIV;
          ret_nxt   = L_QA;
        end
      end
      L_QA:   begin state_nxt = S_DIV; ret_nxt = L_QB; end
      L_QB:   state_nxt = S_IDLE;
      K_TT:   begin state_nxt = S_MUL; ret_nxt = K_TTT; end
      K_TTT:  begin state_nxt = S_MUL; ret_nxt = K_P1; end
      K_P1:   begin state_nxt = S_MUL; ret_nxt = K_P2; end
      K_P2:   begin state_nxt = S_MUL; ret_nxt = K_P3; end
      K_P3:   begin state_nxt = S_MUL; ret_nxt = K_S1; end
      K_S1:   begin state_nxt = S_MUL; ret_nxt = K_S2; end
      K_S2:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mcnt_nxt      = 2'd0;
    dcnt_nxt      = 6'd0;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    acc_nxt       = acc_r;
    wk_nxt        = wk_r;
    b_nxt         = b_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    neg_nxt       = neg_r;
    t2_nxt        = t2_r;
    t3_nxt        = t3_r;
    tt_nxt        = tt_r;
    d_nxt         = d_r;
    sv_nxt        = sv_r;
    sv2_nxt       = sv2_r;
    base_pos_nxt  = base_pos_r;
    base_spd_nxt  = base_spd_r;
    seg_len_nxt   = seg_len_r;
    step_nxt      = step_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    cc_nxt        = cc_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_spd_nxt   = out_spd_r;
    out_step_nxt  = out_step_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_LOAD) begin
            seg_len_nxt  = in_ch.duration[DB-1:0];
            base_pos_nxt = in_ch.start_position;
            base_spd_nxt = in_ch.start_speed;
            step_nxt     = '0;
            cc_nxt       = 64'(in_ch.start_speed) << (FRAC_BITS - 4);
            d_nxt        = 33'(in_ch.start_position) - 33'(in_ch.end_position);
            sv_nxt       = 17'(in_ch.start_speed) + 17'(in_ch.end_speed);
            sv2_nxt      = 18'(in_ch.start_speed) + 18'(in_ch.start_speed)
                           + 18'(in_ch.end_speed);
            mx_nxt       = 64'(in_ch.duration[DB-1:0]);
            my_nxt       = 64'(in_ch.duration[DB-1:0]);
          end else if (tick_live) begin
            step_nxt = step_r + DB'(1);
            mx_nxt   = 64'(DB'(step_r + DB'(1)));
            my_nxt   = 64'(DB'(step_r + DB'(1)));
          end
        end
      end
      S_MUL: begin
        mcnt_nxt = (mcnt_r == 2'd3) ? 2'd0 : mcnt_r + 2'd1;
        case (mcnt_r)
          2'd0:    acc_nxt = acc_r;
          2'd1:    acc_nxt = prod_r;
          default: acc_nxt = acc_r + {prod_r[31:0], 32'd0};
        endcase
      end
      S_DIV: begin
        dcnt_nxt = (dcnt_r == 6'(DIV_STEPS - 1)) ? 6'd0 : dcnt_r + 6'd1;
        rem_nxt  = qbit ? rem_diff[T3_W-1:0] : rem_sh[T3_W-1:0];
        num_nxt  = {num_r[62:0], qbit};
      end
      L_T2: begin
        t2_nxt = acc_r[T2_W-1:0];
        mx_nxt = 64'(acc_r[T2_W-1:0]);
        my_nxt = 64'(seg_len_r);
      end
      L_T3: begin
        t3_nxt = acc_r[T3_W-1:0];
        mx_nxt = 64'(seg_len_r);
        my_nxt = 64'(sv_r);
      end
      L_M1: begin
        wk_nxt = ((d64 << 1) + {{4{acc_r[63]}}, acc_r[63:4]}) << FRAC_BITS;
        mx_nxt = 64'(seg_len_r);
        my_nxt = 64'(sv2_r);
      end
      L_M2: begin
        b_nxt = (64'd0 - ((d64 << 1) + d64 + {{4{acc_r[63]}}, acc_r[63:4]}))
                << FRAC_BITS;
        if (seg_len_r == '0) begin
          ca_nxt = 64'd0;
          cb_nxt = 64'd0;
        end else begin
          neg_nxt = pre_neg;
          num_nxt = pre_num;
          rem_nxt = '0;
          dv_nxt  = t3_r;
        end
      end
      L_QA: begin
        ca_nxt  = q_fix;
        neg_nxt = pre_neg;
        num_nxt = pre_num;
        rem_nxt = '0;
        dv_nxt  = T3_W'(t2_r);
      end
      L_QB: cb_nxt = q_fix;
      K_TT: begin
        tt_nxt = acc_r[T2_W-1:0];
        mx_nxt = 64'(acc_r[T2_W-1:0]);
        my_nxt = 64'(step_r);
      end
      K_TTT: begin
        mx_nxt = ca_r;
        my_nxt = acc_r;
      end
      K_P1: begin
        wk_nxt = acc_r;
        mx_nxt = cb_r;
        my_nxt = 64'(tt_r);
      end
      K_P2: begin
        wk_nxt = sum64;
        mx_nxt = cc_r;
        my_nxt = 64'(step_r);
      end
      K_P3: begin
        pos_nxt = sum64[FRAC_BITS+31:FRAC_BITS] + base_pos_r;
        mx_nxt  = ca_r;
        my_nxt  = (64'(tt_r) << 5) + (64'(tt_r) << 4);
      end
      K_S1: begin
        wk_nxt = acc_r;
        mx_nxt = cb_r;
        my_nxt = 64'(step_r) << 5;
      end
      K_S2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_spd_nxt   = spd17[16:1];
          out_step_nxt  = STEP_W'(step_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      mcnt_r      <= 2'd0;
      dcnt_r      <= 6'd0;
      out_valid_r <= 1'b0;
      seg_len_r   <= '0;
      step_r      <= '0;
      base_pos_r  <= '0;
      base_spd_r  <= '0;
      ca_r        <= 64'd0;
      cb_r        <= 64'd0;
      cc_r        <= 64'd0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      mcnt_r      <= mcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      seg_len_r   <= seg_len_nxt;
      step_r      <= step_nxt;
      base_pos_r  <= base_pos_nxt;
      base_spd_r  <= base_spd_nxt;
      ca_r        <= ca_nxt;
      cb_r        <= cb_nxt;
      cc_r        <= cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    wk_r       <= wk_nxt;
    b_r        <= b_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    neg_r      <= neg_nxt;
    t2_r       <= t2_nxt;
    t3_r       <= t3_nxt;
    tt_r       <= tt_nxt;
    d_r        <= d_nxt;
    sv_r       <= sv_nxt;
    sv2_r      <= sv2_nxt;
    pos_r      <= pos_nxt;
    out_pos_r  <= out_pos_nxt;
    out_spd_r  <= out_spd_nxt;
    out_step_r <= out_step_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/chsi_checker.sv -----
// ----------------------------------------------------------------------------
// chsi_checker - port-level checks for the segment interpolator
// Result beat hold, busy after load, result timing and step range.
// ----------------------------------------------------------------------------
`default_nettype none

module chsi_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input chsi_pkg::cmd_t  in_cmd,
  input logic            out_valid,
  input logic            out_ready,
  input chsi_pkg::pos_t  out_desired_position,
  input chsi_pkg::spd_t  out_speed_feedforward,
  input chsi_pkg::step_t out_step_index
);

  import chsi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_desired_position)
      && $stable(out_speed_feedforward) && $stable(out_step_index))
    else $error("result beat dropped or changed while stalled");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_LOAD) |=> !in_ready)
    else $error("ready after load beat");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat without sequencer work");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_step_index != '0))
    else $error("zero step index on result beat");

endmodule

bind cubic_hermite_segment_interpolator chsi_checker u_chsi_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .in_cmd                (in_ch.cmd),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_desired_position  (out_ch.desired_position),
  .out_speed_feedforward (out_ch.speed_feedforward),
  .out_step_index        (out_ch.step_index)
);

`default_nettype wire
